// ===== sv/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_WIDTH_BITS = 11;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int ROW_W = 12;
	localparam int COL_W = 10;

	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_blue;
		logic [7:0] pixel_green;
		logic [7:0] pixel_red;
	} pix_in_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_column;
		logic [7:0]       out_blue;
		logic [7:0]       out_green;
		logic [7:0]       out_red;
		logic             last_of_run;
	} pix_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== sv/sem_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW = 10,
	parameter int DW = 48
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/sem_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_lane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [8:0][7:0] win,
	output logic                 done,
	output logic [7:0]           mag
);

	logic signed [10:0] gx, gy;
	logic [19:0] sq_x_s1, sq_y_s1;
	logic [20:0] v_q;
	logic [7:0]  mag_q, bit_q, t;
	logic        sq_vld_q, root_q, done_q;

	assign gx = 11'({3'b0, win[2]} + {2'b0, win[5], 1'b0} + {3'b0, win[8]}
		- {3'b0, win[0]} - {2'b0, win[3], 1'b0} - {3'b0, win[6]});
	assign gy = 11'({3'b0, win[6]} + {2'b0, win[7], 1'b0} + {3'b0, win[8]}
		- {3'b0, win[0]} - {2'b0, win[1], 1'b0} - {3'b0, win[2]});
	assign t = mag_q | bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_q <= 1'b0;
			root_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			sq_vld_q <= 1'b1;
			root_q <= 1'b0;
			done_q <= 1'b0;
		end else if (sq_vld_q) begin
			sq_vld_q <= 1'b0;
			root_q <= 1'b1;
		end else if (root_q) begin
			if (bit_q == 8'h01) begin
				root_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sq_x_s1 <= 20'(gx * gx);
			sq_y_s1 <= 20'(gy * gy);
		end else if (sq_vld_q) begin
			v_q <= 21'(sq_x_s1) + 21'(sq_y_s1);
			bit_q <= 8'h80;
			mag_q <= 8'h00;
		end else if (root_q) begin
			// one result bit per cycle, msb first; a saturated lane keeps step
			if (v_q[20:16] != 5'd0) begin
				mag_q <= 8'hFF;
			end else if (16'(t * t) <= v_q[15:0]) begin
				mag_q <= t;
			end
			bit_q <= bit_q >> 1;
		end
	end

	assign done = done_q;
	assign mag = mag_q;

endmodule
`default_nettype wire

// ===== sv/sobel_edge_magnitude_rgb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sobel edge magnitude on an RGB raster stream. One pixel word is taken, its line store
// entry is read and rewritten, and then, for an interior pixel, three channel lanes form
// gx and gy, square them and take an exact integer square root one bit per cycle (saturated
// to 255). A pixel that causes no result returns straight to idle; otherwise its result
// words follow one per accepted transfer, after the bit-serial root in the lanes when a
// magnitude is needed, and no new pixel is taken until the last word is accepted. Results
// lag the input by one row and one column; border pixels come out unchanged and each word
// carries its row and column, with last_of_run on the final word caused by an input pixel.
module sobel_edge_magnitude_rgb_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pixel_valid,
	output logic                             pixel_ready,
	input  wire sem_pkg::pix_in_t            pixel,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output sem_pkg::pix_out_t                result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

	state_t state_q, state_d;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [23:0]   p_q, prev_q;
	logic [23:0]   win_q [9];
	logic [23:0]   win_d [9];
	logic [47:0]   rd_data;
	logic [23:0]   up, mid;
	pix_out_t      ent_q [4];
	pix_out_t      ent_d [4];
	logic [2:0]    n_q, n_d;
	logic [1:0]    idx_q;
	logic          need_d, lane_start;
	logic [2:0]    lane_done;
	logic [2:0][7:0] lane_mag;
	logic          endrow, lastrow, r_ge1, c_ge1, border, in_acc, out_acc;
	logic [WW:0]   col_x;
	logic [HW:0]   row_x;
	int            wv, hv;

	assign in_acc = pixel_valid && pixel_ready;
	assign out_acc = result_valid && result_ready;
	assign cfg_ready = 1'b1;

	assign wv = int'(cfg_data[CFG_WIDTH_BITS-1:0]);
	assign hv = int'(cfg_data[CFG_HEIGHT_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: w_q <= (wv < 3) ? WW'(3) :
					(wv > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(wv);
				CFG_IMAGE_HEIGHT: h_q <= (hv < 3) ? HW'(3) :
					(hv > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(hv);
				default: ;
			endcase
		end
	end

	sem_line_buf #(.DEPTH(MAX_WIDTH), .AW(CW), .DW(48)) u_line (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (state_q == ST_READ),
		.wr_addr (col_q),
		.wr_data ({rd_data[23:0], p_q})
	);

	assign up = rd_data[47:24];
	assign mid = rd_data[23:0];

	assign col_x = (WW+1)'(col_q);
	assign row_x = (HW+1)'(row_q);
	assign endrow = (col_x + (WW+1)'(1)) >= (WW+1)'(w_q);
	assign lastrow = (row_x + (HW+1)'(1)) >= (HW+1)'(h_q);
	assign r_ge1 = row_q != RW'(0);
	assign c_ge1 = col_q != CW'(0);
	assign border = (row_q == RW'(1)) || (col_q == CW'(1)) ||
		(row_x >= (HW+1)'(h_q)) || (col_x >= (WW+1)'(w_q));

	function automatic pix_out_t mk(input logic [RW-1:0] r, input logic [CW-1:0] c,
		input logic [23:0] px);
		pix_out_t o;
		o.out_row = ROW_W'(r);
		o.out_column = COL_W'(c);
		o.out_red = px[23:16];
		o.out_green = px[15:8];
		o.out_blue = px[7:0];
		o.last_of_run = 1'b0;
		return o;
	endfunction

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_d[k*3] = win_q[k*3+1];
			win_d[k*3+1] = win_q[k*3+2];
		end
		win_d[2] = up;
		win_d[5] = mid;
		win_d[8] = p_q;
	end

	// result list for this pixel, in output order
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ent_d[k] = ent_q[k];
		end
		n_d = 3'd0;
		need_d = 1'b0;
		if (r_ge1 && c_ge1) begin
			ent_d[n_d[1:0]] = mk(row_q - RW'(1), col_q - CW'(1), win_q[5]);
			need_d = !border;
			n_d = n_d + 3'd1;
		end
		if (r_ge1 && endrow) begin
			ent_d[n_d[1:0]] = mk(row_q - RW'(1), col_q, mid);
			n_d = n_d + 3'd1;
		end
		if (lastrow && c_ge1) begin
			ent_d[n_d[1:0]] = mk(row_q, col_q - CW'(1), prev_q);
			n_d = n_d + 3'd1;
		end
		if (lastrow && endrow) begin
			ent_d[n_d[1:0]] = mk(row_q, col_q, p_q);
			n_d = n_d + 3'd1;
		end
	end

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : gen_lane
			logic [8:0][7:0] lw;
			always_comb begin
				for (int k = 0; k < 9; k++) begin
					lw[k] = win_d[k][g*8 +: 8];
				end
			end
			sem_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (lane_start),
				.win    (lw),
				.done   (lane_done[g]),
				.mag    (lane_mag[g])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_READ;
			ST_READ: begin
				if (n_d == 3'd0) state_d = ST_IDLE;
				else if (need_d) state_d = ST_CALC;
				else state_d = ST_EMIT;
			end
			ST_CALC: if (lane_done[0]) state_d = ST_EMIT;
			ST_EMIT: if (out_acc && (3'(idx_q) + 3'd1 == n_q)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pixel_ready = state_q == ST_IDLE;
		result_valid = state_q == ST_EMIT;
		lane_start = (state_q == ST_READ) && need_d;
		result = ent_q[idx_q];
		result.last_of_run = 3'(idx_q) + 3'd1 == n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			prev_q <= '0;
			n_q <= 3'd0;
			idx_q <= 2'd0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				n_q <= n_d;
				idx_q <= 2'd0;
				prev_q <= p_q;
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= win_d[k];
				end
				if (endrow) begin
					col_q <= '0;
					row_q <= lastrow ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (out_acc) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q <= {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};
		end
		if (state_q == ST_READ) begin
			for (int k = 0; k < 4; k++) begin
				ent_q[k] <= ent_d[k];
			end
		end else if (state_q == ST_CALC && lane_done[0]) begin
			ent_q[0].out_blue <= lane_mag[0];
			ent_q[0].out_green <= lane_mag[1];
			ent_q[0].out_red <= lane_mag[2];
		end
	end

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> 3'(idx_q) < n_q)
		else $error("emit index past result count");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
		else $error("lanes out of step");

	a_calc_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && lane_done[0] |=> state_q == ST_EMIT)
		else $error("magnitude lost");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pixel_ready && result_valid))
		else $error("input taken while results pending");

endmodule
`default_nettype wire

// ===== verif/tb_sobel_edge_magnitude_rgb_top.sv =====
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude_rgb_top;
	import sem_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	pix_in_t pixel = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	pix_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sobel_edge_magnitude_rgb_top dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [23:0] upper_row [0:1023];
	logic [23:0] middle_row [0:1023];
	logic [23:0] win [0:8];
	int unsigned row_pos, col_pos, frame_w, frame_h;
	logic [23:0] prev_px;

	pix_in_t pixel_queue[$];
	pix_out_t expected_words[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	int fail_count = 0;
	bit feeding = 0;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [7:0] root_sat(int unsigned v);
		int unsigned r, t;
		r = 0;
		if (v >= 65536) return 8'd255;
		for (int b = 7; b >= 0; b--) begin
			t = r | (1 << b);
			if (t * t <= v) r = t;
		end
		return r[7:0];
	endfunction

	function automatic logic [23:0] edge_mag();
		logic [23:0] m;
		int w [0:8];
		int gx, gy;
		for (int s = 0; s < 24; s += 8) begin
			for (int k = 0; k < 9; k++) w[k] = int'((win[k] >> s) & 24'hff);
			gx = (w[2] + 2 * w[5] + w[8]) - (w[0] + 2 * w[3] + w[6]);
			gy = (w[6] + 2 * w[7] + w[8]) - (w[0] + 2 * w[1] + w[2]);
			m[s +: 8] = root_sat(gx * gx + gy * gy);
		end
		return m;
	endfunction

	function automatic void push_word(ref pix_out_t words[$], input int unsigned r,
		input int unsigned c, input logic [23:0] px);
		pix_out_t o;
		o.out_row = r[ROW_W-1:0];
		o.out_column = c[COL_W-1:0];
		o.out_blue = px[7:0];
		o.out_green = px[15:8];
		o.out_red = px[23:16];
		o.last_of_run = 1'b0;
		words.push_back(o);
	endfunction

	task automatic predict_pixel(input pix_in_t p_in);
		logic [23:0] p, up, mid, v;
		int unsigned r, c, orow, ocol;
		bit endrow, lastrow, border;
		pix_out_t words[$];
		p = {p_in.pixel_red, p_in.pixel_green, p_in.pixel_blue};
		r = row_pos;
		c = col_pos;
		endrow = c >= frame_w - 1;
		lastrow = r >= frame_h - 1;
		up = '0;
		mid = '0;
		if (c < 1024) begin
			up = upper_row[c];
			mid = middle_row[c];
		end
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = p;
		if (r >= 1 && c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
			border = orow == 0 || ocol == 0 || orow >= frame_h - 1 || ocol >= frame_w - 1;
			v = border ? win[4] : edge_mag();
			push_word(words, orow, ocol, v);
		end
		if (r >= 1 && endrow) push_word(words, r - 1, c, mid);
		if (lastrow && c >= 1) push_word(words, r, c - 1, prev_px);
		if (lastrow && endrow) push_word(words, r, c, p);
		if (words.size() > 0) words[words.size()-1].last_of_run = 1'b1;
		foreach (words[i]) expected_words.push_back(words[i]);
		if (c < 1024) begin
			upper_row[c] = mid;
			middle_row[c] = p;
		end
		prev_px = p;
		if (endrow) begin
			col_pos = 0;
			row_pos = lastrow ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// pixel driver
	always @(posedge clk) begin
		if (pixel_valid && pixel_ready) predict_pixel(pixel);
		if (!(pixel_valid && !pixel_ready)) begin
			if (feeding && pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pixel <= pixel_queue.pop_front();
				pixel_valid <= 1'b1;
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		pix_out_t e;
		if (result_valid && result_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word row=%0d col=%0d", result.out_row, result.out_column);
				fail_count++;
			end else begin
				e = expected_words.pop_front();
				if (result.out_row !== e.out_row) begin
					$error("out_row exp %0d got %0d", e.out_row, result.out_row);
					fail_count++;
				end
				if (result.out_column !== e.out_column) begin
					$error("out_column exp %0d got %0d", e.out_column, result.out_column);
					fail_count++;
				end
				if (result.out_blue !== e.out_blue) begin
					$error("out_blue exp %0d got %0d", e.out_blue, result.out_blue);
					fail_count++;
				end
				if (result.out_green !== e.out_green) begin
					$error("out_green exp %0d got %0d", e.out_green, result.out_green);
					fail_count++;
				end
				if (result.out_red !== e.out_red) begin
					$error("out_red exp %0d got %0d", e.out_red, result.out_red);
					fail_count++;
				end
				if (result.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0d got %0d", e.last_of_run, result.last_of_run);
					fail_count++;
				end
			end
		end
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_reg(input logic idx, input int unsigned value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH) frame_w = clamp_dim(value & 11'h7ff, 3, 1024);
		else frame_h = clamp_dim(value & 13'h1fff, 3, 4096);
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || pixel_valid || expected_words.size() > 0)
			@(posedge clk);
		feeding = 1'b0;
		// idle-pixel work after last word may still be in flight
		repeat (40) @(posedge clk);
	endtask

	function automatic pix_in_t rand_pixel(int mode);
		pix_in_t p;
		p = 24'($urandom());
		if (mode == 1) p = '0;
		else if (mode == 2) p = '1;
		else if (mode == 3 && $urandom_range(1)) p = '1;
		else if (mode == 3) p = '0;
		return p;
	endfunction

	// whole frames only, so every frame starts at row 0, column 0
	task automatic queue_frame(int unsigned w, int unsigned h, int mode);
		for (int i = 0; i < w * h; i++) pixel_queue.push_back(rand_pixel(mode));
	endtask

	initial begin
		int unsigned w, h;
		for (int i = 0; i < 1024; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		for (int k = 0; k < 9; k++) win[k] = '0;
		row_pos = 0;
		col_pos = 0;
		prev_px = '0;
		frame_w = 640;
		frame_h = 480;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: minimum frame, extremes, random black/white pixels for saturation
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 3);
		queue_frame(3, 3, 1);
		queue_frame(3, 3, 3);
		feeding = 1'b1;
		drain();
		// out-of-range values clamp to the minimum
		write_reg(CFG_IMAGE_WIDTH, 0);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		queue_frame(3, 3, 2);
		feeding = 1'b1;
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 82 : 0;
			recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 12 : 0;
			for (int f = 0; f < 4; f++) begin
				w = $urandom_range(3, 8);
				h = $urandom_range(3, 6);
				write_reg(CFG_IMAGE_WIDTH, w);
				write_reg(CFG_IMAGE_HEIGHT, h);
				queue_frame(w, h, ($urandom_range(3) == 0) ? 3 : 0);
				feeding = 1'b1;
				drain();
			end
		end

		// wide row, and height past the maximum clamps to 4096 (only a few rows sent)
		write_reg(CFG_IMAGE_WIDTH, 40);
		write_reg(CFG_IMAGE_HEIGHT, 3);
		queue_frame(40, 3, 0);
		feeding = 1'b1;
		drain();
		write_reg(CFG_IMAGE_WIDTH, 4);
		write_reg(CFG_IMAGE_HEIGHT, 8191);
		queue_frame(4, 4, 0);
		feeding = 1'b1;
		drain();
		if (fail_count == 0) $display("[sobel_edge_magnitude_rgb_top] OK");
		else $display("[sobel_edge_magnitude_rgb_top] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[sobel_edge_magnitude_rgb_top] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/sem_pkg.sv
sv/sem_line_buf.sv
sv/sem_lane.sv
sv/sobel_edge_magnitude_rgb_top.sv
verif/tb_sobel_edge_magnitude_rgb_top.sv
